// ===== rtl/two_level_page_table_manager_assert.svh =====
// Assertion macros for the page table manager.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define TLPTM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define TLPTM_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLPTM_NEVER(label, cond, msg)
`define TLPTM_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/tlptm_pkg.sv =====
// Shared types, codes and helpers for the page table manager.
// No dependencies.
package tlptm_pkg;

    localparam int TABLE_POOL_DEF = 16;
    localparam int DIR_ENTRIES    = 1024;
    localparam int CNT_W          = 21;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [2:0] STAT_SUCCESS    = 3'd0;
    localparam logic [2:0] STAT_NOT_MAPPED = 3'd1;
    localparam logic [2:0] STAT_MISALIGNED = 3'd2;
    localparam logic [2:0] STAT_NO_TABLE   = 3'd3;
    localparam logic [2:0] STAT_ALREADY    = 3'd4;

    localparam logic CFG_KERNEL_BASE      = 1'b0;
    localparam logic CFG_LOW_KERNEL_LIMIT = 1'b1;

    localparam logic [31:0] KERNEL_BASE_RST = 32'hC000_0000;
    localparam logic [31:0] LOW_LIMIT_RST   = 32'h0100_0000;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TBL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] virtual_address;
        logic [31:0] physical_address;
        logic [11:0] entry_flags;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      translated_address;
        logic [CNT_W-1:0] mapped_total;
        logic [CNT_W-1:0] kernel_total;
        logic [CNT_W-1:0] nonkernel_total;
        logic [4:0]       tables_used;
    } rsp_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic dir_stage;
        logic tbl_stage;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic dir_end;
        logic out_free;
    } sts_t;

    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        dec_sat = (v == '0) ? v : v - 1'b1;
    endfunction

endpackage

// ===== rtl/tlptm_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module tlptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/tlptm_ctrl.sv =====
// Sequencer for the page table manager: clear pass, then one request at a time.
// Depends on tlptm_pkg.
module tlptm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tlptm_pkg::sts_t sts,
    output tlptm_pkg::cmd_t cmd
);
    import tlptm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.dir_stage = 1'b1;
                state_next    = sts.dir_end ? S_DONE : S_TBL;
            end
            S_TBL:
            begin
                cmd.tbl_stage = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== rtl/tlptm_dp.sv =====
// Datapath: directory and table RAMs, counters, config and result register.
// Depends on tlptm_pkg and tlptm_ram.
module tlptm_dp #(
    parameter int TABLE_POOL = tlptm_pkg::TABLE_POOL_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tlptm_pkg::req_t req,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data,
    input  tlptm_pkg::cmd_t cmd,
    output tlptm_pkg::sts_t sts,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tlptm_pkg::rsp_t rsp
);
    import tlptm_pkg::*;

    localparam int TW    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int NW    = $clog2(TABLE_POOL + 1);
    localparam int AW    = TW + 10;
    localparam int DW    = TW + 3;
    localparam int TOTAL = TABLE_POOL * 1024;

    req_t             req_reg;
    logic [2:0]       stat_reg, stat_next;
    logic [31:0]      xlat_reg, xlat_next;
    logic [TW-1:0]    tbl_reg, tbl_next;
    logic [NW-1:0]    next_tbl_reg, next_tbl_next;
    logic [CNT_W-1:0] mapped_reg, mapped_next;
    logic [CNT_W-1:0] kernel_reg, kernel_next;
    logic [CNT_W-1:0] user_reg, user_next;
    logic [AW-1:0]    sweep_reg;
    logic [31:0]      kbase_reg, klim_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;

    logic             dir_we, tbl_we;
    logic [9:0]       dir_addr;
    logic [DW-1:0]    dir_wdata, dir_rdata;
    logic [AW-1:0]    tbl_addr;
    logic [31:0]      tbl_wdata, tbl_rdata;
    logic             present, misaligned, pool_full, is_kernel, valid;
    logic [TW-1:0]    dir_tbl, tbl_sel;
    logic [NW+4:0]    used_ext;
    op_t              op;

    assign op         = op_t'(req_reg.operation);
    assign present    = dir_rdata[DW-1];
    assign dir_tbl    = dir_rdata[TW-1:0];
    assign misaligned = (req_reg.virtual_address[11:0] != '0)
                     || (req_reg.physical_address[11:0] != '0);
    assign pool_full  = next_tbl_reg >= NW'(TABLE_POOL);
    assign tbl_sel    = present ? dir_tbl : next_tbl_reg[TW-1:0];
    assign valid      = tbl_rdata[0];
    assign is_kernel  = (req_reg.virtual_address >= kbase_reg)
                     || (req_reg.virtual_address < klim_reg);
    assign used_ext   = {5'b0, next_tbl_reg};

    assign sts.sweep_last = sweep_reg == AW'(TOTAL - 1);
    assign sts.dir_end    = (op == OP_NONE)
                         || ((op == OP_MAP) && (misaligned || (!present && pool_full)))
                         || ((op != OP_MAP) && !present);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    // memory ports
    always_comb
    begin
        dir_we    = 1'b0;
        dir_wdata = '0;
        tbl_we    = 1'b0;
        tbl_wdata = '0;
        dir_addr  = cmd.accept ? req.virtual_address[31:22]
                               : req_reg.virtual_address[31:22];
        tbl_addr  = cmd.dir_stage ? {tbl_sel, req_reg.virtual_address[21:12]}
                                  : {tbl_reg, req_reg.virtual_address[21:12]};
        if (cmd.clear_step)
        begin
            dir_addr = sweep_reg[9:0];
            tbl_addr = sweep_reg;
            dir_we   = 1'b1;
            tbl_we   = 1'b1;
        end
        else if (cmd.dir_stage && !sts.dir_end && (op == OP_MAP) && !present)
        begin
            // allocate a fresh table; cleared at reset, never reused
            dir_we    = 1'b1;
            dir_wdata = {1'b1, req_reg.entry_flags[2:1], next_tbl_reg[TW-1:0]};
        end
        else if (cmd.tbl_stage)
        begin
            if ((op == OP_MAP) && !valid)
            begin
                tbl_we    = 1'b1;
                tbl_wdata = {req_reg.physical_address[31:12],
                             req_reg.entry_flags[11:1], 1'b1};
            end
            else if ((op == OP_UNMAP) && valid)
            begin
                tbl_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat_next     = stat_reg;
        xlat_next     = xlat_reg;
        tbl_next      = tbl_reg;
        next_tbl_next = next_tbl_reg;
        mapped_next   = mapped_reg;
        kernel_next   = kernel_reg;
        user_next     = user_reg;
        if (cmd.dir_stage)
        begin
            xlat_next = '0;
            tbl_next  = tbl_sel;
            if (op == OP_MAP && misaligned)
            begin
                stat_next = STAT_MISALIGNED;
            end
            else if (op == OP_MAP && !present && pool_full)
            begin
                stat_next = STAT_NO_TABLE;
            end
            else
            begin
                stat_next = STAT_NOT_MAPPED;
            end
            if (!sts.dir_end && (op == OP_MAP) && !present)
            begin
                next_tbl_next = next_tbl_reg + 1'b1;
            end
        end
        else if (cmd.tbl_stage)
        begin
            case (op)
                OP_MAP:
                begin
                    if (valid)
                    begin
                        stat_next = STAT_ALREADY;
                    end
                    else
                    begin
                        stat_next   = STAT_SUCCESS;
                        mapped_next = mapped_reg + 1'b1;
                        if (is_kernel)
                        begin
                            kernel_next = kernel_reg + 1'b1;
                        end
                        else
                        begin
                            user_next = user_reg + 1'b1;
                        end
                    end
                end
                OP_UNMAP:
                begin
                    if (valid)
                    begin
                        stat_next   = STAT_SUCCESS;
                        mapped_next = dec_sat(mapped_reg);
                        if (is_kernel)
                        begin
                            kernel_next = dec_sat(kernel_reg);
                        end
                        else
                        begin
                            user_next = dec_sat(user_reg);
                        end
                    end
                end
                OP_XLATE:
                begin
                    if (valid)
                    begin
                        stat_next = STAT_SUCCESS;
                        xlat_next = {tbl_rdata[31:12], req_reg.virtual_address[11:0]};
                    end
                end
                default:
                begin
                    stat_next = STAT_NOT_MAPPED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_tbl_reg  <= '0;
            mapped_reg    <= '0;
            kernel_reg    <= '0;
            user_reg      <= '0;
            sweep_reg     <= '0;
            kbase_reg     <= KERNEL_BASE_RST;
            klim_reg      <= LOW_LIMIT_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            next_tbl_reg <= next_tbl_next;
            mapped_reg   <= mapped_next;
            kernel_reg   <= kernel_next;
            user_reg     <= user_next;
            if (cmd.clear_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KERNEL_BASE:      kbase_reg <= cfg_data;
                    CFG_LOW_KERNEL_LIMIT: klim_reg  <= cfg_data;
                    default:              kbase_reg <= kbase_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        stat_reg <= stat_next;
        xlat_reg <= xlat_next;
        tbl_reg  <= tbl_next;
        if (cmd.out_load)
        begin
            rsp_reg.status             <= stat_reg;
            rsp_reg.translated_address <= xlat_reg;
            rsp_reg.mapped_total       <= mapped_reg;
            rsp_reg.kernel_total       <= kernel_reg;
            rsp_reg.nonkernel_total    <= user_reg;
            rsp_reg.tables_used        <= used_ext[4:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tlptm_ram #(.WIDTH(DW), .DEPTH(DIR_ENTRIES)) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .addr  (dir_addr),
        .wdata (dir_wdata),
        .rdata (dir_rdata)
    );

    tlptm_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );
endmodule

// ===== rtl/two_level_page_table_manager.sv =====
// Two-level page table manager: map, unmap and translate of 4K pages.
// Request channel req_valid/req_ready carries req (operation, addresses, flags).
// Response channel rsp_valid/rsp_ready returns one rsp per request: status,
// translated address, page counts and tables handed out.
// cfg_we/cfg_index/cfg_data write kernel_base (0) and low_kernel_limit (1);
// write them only while no request is in flight.
// A request passes the directory lookup state, then the page table entry state
// unless it ends at the directory, then a done state that loads the result
// into the output register once that register is free; the next request is
// taken back in idle. The dependent directory read, table read and write-back
// go through single-port RAMs. After reset the block sweeps both RAMs to zero
// with req_ready low; config writes are taken during the sweep.
// The response sits in an output register; if the receiver stalls, one more
// request is accepted and parked until the register frees up.
// Depends on tlptm_pkg, tlptm_ctrl, tlptm_dp and the assert header.
module two_level_page_table_manager #(
    parameter int TABLE_POOL = tlptm_pkg::TABLE_POOL_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tlptm_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tlptm_pkg::rsp_t rsp,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);
    import tlptm_pkg::*;

`include "two_level_page_table_manager_assert.svh"

    cmd_t cmd;
    sts_t sts;
    logic rsp_fail;

    tlptm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlptm_dp #(.TABLE_POOL(TABLE_POOL)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_fail = rsp_valid && (rsp.status != STAT_SUCCESS);

    `TLPTM_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken")
    `TLPTM_NEVER(a_xlat_zero, rsp_fail && rsp.translated_address != 32'd0, "address on failed op")
    `TLPTM_NEVER(a_load_busy, cmd.out_load && rsp_valid && !rsp_ready, "response overwritten")
endmodule

// ===== tb/tb.sv =====
// Testbench for two_level_page_table_manager: map, unmap and translate requests.
// Predicts each response with its own page table model; needs tlptm_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import tlptm_pkg::*;

    localparam int POOL = 16;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    two_level_page_table_manager #(.TABLE_POOL(POOL)) uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow page table
    logic        dir_present [DIR_ENTRIES];
    logic [4:0]  dir_table [DIR_ENTRIES];
    logic [31:0] pte_word [POOL*1024];
    logic        pte_valid [POOL*1024];
    logic [4:0]  tables_out;
    logic [20:0] pages_mapped, pages_kernel, pages_user;
    logic [31:0] kbase, klow;

    rsp_t        pending_rsp [$];
    int          errors;
    int          sent, received, cycles;
    int          stall_hold;
    int          op_seen [4];
    logic [31:0] used_va [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic in_kernel(input logic [31:0] va);
        in_kernel = (va >= kbase) || (va < klow);
    endfunction

    function automatic logic [20:0] dec_floor(input logic [20:0] v);
        dec_floor = (v == 0) ? v : v - 1;
    endfunction

    function automatic rsp_t page_table_step(input req_t r);
        rsp_t        o;
        logic [9:0]  d;
        logic [9:0]  t;
        int          s;
        d = r.virtual_address[31:22];
        t = r.virtual_address[21:12];
        o = '0;
        o.status = STAT_NOT_MAPPED;
        s = dir_present[d] ? dir_table[d] * 1024 + t : -1;
        case (op_t'(r.operation))
            OP_MAP:
            begin
                if (r.virtual_address[11:0] != 0 || r.physical_address[11:0] != 0)
                    o.status = STAT_MISALIGNED;
                else if (!dir_present[d] && tables_out >= POOL)
                    o.status = STAT_NO_TABLE;
                else
                begin
                    if (!dir_present[d])
                    begin
                        for (int i = 0; i < 1024; i++)
                            pte_valid[tables_out*1024 + i] = 1'b0;
                        dir_present[d] = 1'b1;
                        dir_table[d] = tables_out;
                        tables_out = tables_out + 1;
                        s = dir_table[d] * 1024 + t;
                    end
                    if (pte_valid[s])
                        o.status = STAT_ALREADY;
                    else
                    begin
                        pte_word[s] = {r.physical_address[31:12], r.entry_flags | 12'h001};
                        pte_valid[s] = 1'b1;
                        pages_mapped = pages_mapped + 1;
                        if (in_kernel(r.virtual_address))
                            pages_kernel = pages_kernel + 1;
                        else
                            pages_user = pages_user + 1;
                        o.status = STAT_SUCCESS;
                    end
                end
            end
            OP_UNMAP:
            begin
                if (s >= 0 && pte_valid[s])
                begin
                    pte_valid[s] = 1'b0;
                    pte_word[s] = '0;
                    pages_mapped = dec_floor(pages_mapped);
                    if (in_kernel(r.virtual_address))
                        pages_kernel = dec_floor(pages_kernel);
                    else
                        pages_user = dec_floor(pages_user);
                    o.status = STAT_SUCCESS;
                end
            end
            OP_XLATE:
            begin
                if (s >= 0 && pte_valid[s])
                begin
                    o.status = STAT_SUCCESS;
                    o.translated_address = {pte_word[s][31:12], 12'h000}
                                         + r.virtual_address[11:0];
                end
            end
            default: ;
        endcase
        o.mapped_total = pages_mapped;
        o.kernel_total = pages_kernel;
        o.nonkernel_total = pages_user;
        o.tables_used = tables_out;
        return o;
    endfunction

    // sender: hold valid until accepted; bursts with random gaps
    int burst_left;

    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_rsp.push_back(page_table_step(r));
        op_seen[r.operation]++;
        sent++;
        if (r.operation == OP_MAP)
            used_va.push_back(r.virtual_address);
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            received <= received + 1;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected response %p", $realtime, rsp);
                errors++;
            end
            else
            begin
                rsp_t e;
                e = pending_rsp.pop_front();
                if (e.status !== rsp.status)
                    $display("%0t status exp %0d got %0d", $realtime, e.status, rsp.status);
                if (e.translated_address !== rsp.translated_address)
                    $display("%0t xlat exp %h got %h", $realtime,
                             e.translated_address, rsp.translated_address);
                if (e.mapped_total !== rsp.mapped_total)
                    $display("%0t mapped exp %0d got %0d", $realtime,
                             e.mapped_total, rsp.mapped_total);
                if (e.kernel_total !== rsp.kernel_total)
                    $display("%0t kernel exp %0d got %0d", $realtime,
                             e.kernel_total, rsp.kernel_total);
                if (e.nonkernel_total !== rsp.nonkernel_total)
                    $display("%0t user exp %0d got %0d", $realtime,
                             e.nonkernel_total, rsp.nonkernel_total);
                if (e.tables_used !== rsp.tables_used)
                    $display("%0t tables exp %0d got %0d", $realtime,
                             e.tables_used, rsp.tables_used);
                if (e !== rsp)
                    errors++;
            end
        end
    end

    // receiver stall pattern, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            rsp_ready <= 1'b0;
        end
        else if (cycles[9:8] == 2'b00)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KERNEL_BASE)
            kbase = val;
        else
            klow = val;
    endtask

    function automatic req_t make_req(input logic [1:0] op, input logic [31:0] va,
                                      input logic [31:0] pa, input logic [11:0] fl);
        req_t r;
        r.operation = op;
        r.virtual_address = va;
        r.physical_address = pa;
        r.entry_flags = fl;
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_req(OP_XLATE, 32'h0000_0000, 0, 0));
        send_request(make_req(OP_UNMAP, 32'hFFFF_F000, 0, 0));
        send_request(make_req(OP_MAP, 32'h0000_0000, 32'hFFFF_F000, 12'hFFF));
        send_request(make_req(OP_MAP, 32'hFFFF_F000, 32'h0000_0000, 12'h000));
        send_request(make_req(OP_MAP, 32'h4000_0000, 32'h1234_5000, 12'h006));
        send_request(make_req(OP_MAP, 32'h4000_0000, 32'h5555_5000, 12'h002));
        send_request(make_req(OP_MAP, 32'h4000_0001, 32'h1000_0000, 12'h0));
        send_request(make_req(OP_MAP, 32'h4000_1000, 32'h1000_0800, 12'h0));
        send_request(make_req(OP_XLATE, 32'h4000_0ABC, 0, 0));
        send_request(make_req(OP_XLATE, 32'hFFFF_FFFF, 0, 0));
        send_request(make_req(OP_XLATE, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(OP_NONE, 32'h4000_0000, 32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(OP_UNMAP, 32'h4000_0000, 0, 0));
        send_request(make_req(OP_UNMAP, 32'h4000_0000, 0, 0));
        send_request(make_req(OP_XLATE, 32'h4000_0000, 0, 0));
        send_request(make_req(OP_UNMAP, 32'h4040_0000, 0, 0));
        drain();
    endtask

    // exhaust the table pool with one map per directory slot
    task automatic test_pool_exhaustion();
        for (int i = 0; i < POOL + 3; i++)
            send_request(make_req(OP_MAP, {10'(i * 37 + 5), 10'(i), 12'h0},
                                  {20'($urandom), 12'h0}, 12'($urandom)));
        drain();
    endtask

    // kernel range moved between map and unmap; counts saturate
    task automatic test_kernel_range();
        write_reg(CFG_KERNEL_BASE, 32'h0000_0000);
        write_reg(CFG_LOW_KERNEL_LIMIT, 32'h0000_0000);
        send_request(make_req(OP_MAP, 32'h0000_2000, 32'h0000_3000, 12'h004));
        drain();
        write_reg(CFG_KERNEL_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_LOW_KERNEL_LIMIT, 32'h0000_0000);
        send_request(make_req(OP_UNMAP, 32'h0000_2000, 0, 0));
        send_request(make_req(OP_MAP, 32'hFFFF_F000, 32'h0000_3000, 12'h0));
        drain();
    endtask

    function automatic logic [31:0] pick_va();
        if (used_va.size() != 0 && $urandom_range(0, 3) != 0)
            return used_va[$urandom_range(0, used_va.size() - 1)]
                   | ($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 4095)) : 0);
        return $urandom_range(0, 7) == 0 ? $urandom : {$urandom_range(0, 1) ? 10'h3FF
               : 10'($urandom), 10'($urandom), 12'h0};
    endfunction

    task automatic test_random(input int n);
        req_t r;
        for (int i = 0; i < n; i++)
        begin
            r.operation = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
            r.virtual_address = pick_va();
            r.physical_address = ($urandom_range(0, 7) == 0) ? $urandom
                                 : {20'($urandom), 12'h0};
            r.entry_flags = 12'($urandom);
            send_request(r);
        end
        drain();
    endtask

    task automatic test_backpressure();
        stall_hold = 60;
        for (int i = 0; i < 12; i++)
            send_request(make_req(OP_XLATE, pick_va(), 0, 0));
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        errors = 0; sent = 0; received = 0; cycles = 0; stall_hold = 0; burst_left = 0;
        op_seen = '{default: 0};
        for (int i = 0; i < DIR_ENTRIES; i++)
        begin
            dir_present[i] = 1'b0;
            dir_table[i] = '0;
        end
        for (int i = 0; i < POOL*1024; i++)
        begin
            pte_valid[i] = 1'b0;
            pte_word[i] = '0;
        end
        tables_out = 0; pages_mapped = 0; pages_kernel = 0; pages_user = 0;
        kbase = KERNEL_BASE_RST; klow = LOW_LIMIT_RST;
        rst_n = 1'b0; req_valid = 1'b0; req = '0; rsp_ready = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(300);
        write_reg(CFG_KERNEL_BASE, 32'h8000_0000);
        write_reg(CFG_LOW_KERNEL_LIMIT, 32'h0040_0000);
        test_random(300);
        test_pool_exhaustion();
        test_kernel_range();
        test_random(300);
        repeat (20) @(posedge clk);
        $display("tb: %0d requests (map %0d, unmap %0d, translate %0d, unused %0d)",
                 sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("tb: %0d responses checked, %0d tables handed out, %0d mismatches",
                 received, tables_out, errors);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
